[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pooling block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/mp2_pkg.sv]
// ---------------------------------------------------------------------------
// mp2_pkg
// Shared constants for the 2x2 max pooling block.
// ---------------------------------------------------------------------------
package mp2_pkg;

    localparam int MAX_OUT_WIDTH_DEF = 512;
    localparam int PIXEL_BITS_DEF    = 16;
    localparam int CFG_BITS          = 10;
    localparam int CFG_IDX_BITS      = 1;
    localparam int MASK_BITS         = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT = 1'b1;

    // Window mask bit positions.
    localparam int MASK_TL = 0;
    localparam int MASK_TR = 1;
    localparam int MASK_BL = 2;
    localparam int MASK_BR = 3;

endpackage

[hdl/maxpool_2x2_with_argmax_mask.sv]
// ---------------------------------------------------------------------------
// maxpool_2x2_with_argmax_mask
// 2x2 stride-2 max pooling over a raster pixel stream, with an argmax mask.
// ---------------------------------------------------------------------------
// Usage: pixels of one feature map enter in raster order on the input
// channel (i_in_valid / o_in_ready), 2*out_width pixels per row and
// 2*out_height rows; maps follow one another directly. One pixel is taken
// per cycle unless stalled. Only on the bottom-right pixel of each window
// does a result leave on the output channel (o_out_valid / i_out_ready), in
// the cycle after that pixel was taken: the window maximum, a mask of every
// pixel equal to it, and a map-done flag on the last window of the map.
// The top pair of each window sits in a line RAM, written once per pair;
// its single registered read port is addressed on the bottom-left pixel, so
// the data is ready when the bottom-right pixel arrives.
// A full output register parts the two sides: a new request is taken while
// a result waits, provided the receiver takes that result in the same
// cycle; while the receiver stalls with a result held, input stalls too.
// Reset clears the counters and phases and sets both sizes to 1; the line
// RAM is not cleared and needs no clearing pass, as every bottom row reads
// only entries that its top row has written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module maxpool_2x2_with_argmax_mask #(
    parameter int MAX_OUT_WIDTH = mp2_pkg::MAX_OUT_WIDTH_DEF,
    parameter int PIXEL_BITS    = mp2_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [mp2_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [mp2_pkg::CFG_BITS-1:0]        i_cfg_data,
    // Pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [PIXEL_BITS-1:0]        i_pixel_value,
    // Pooled result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [PIXEL_BITS-1:0]        o_pooled_value,
    output logic [mp2_pkg::MASK_BITS-1:0]       o_window_mask,
    output logic                                o_map_done
);

    // Column counter indexes the line RAM directly: it never passes
    // MAX_OUT_WIDTH-1, the largest value of the effective width minus one.
    localparam int CIW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int MXW = $clog2(MAX_OUT_WIDTH + 1);
    // Width for size comparisons, wide enough for the register and the cap.
    localparam int SW  = (mp2_pkg::CFG_BITS > MXW) ? mp2_pkg::CFG_BITS : MXW;
    localparam int CB  = mp2_pkg::CFG_BITS;

    // Configuration registers
    logic [CB-1:0]  r_out_width;
    logic [CB-1:0]  r_out_height;

    // Position state
    logic [CIW-1:0] r_col_index, n_col_index;
    logic [CB-1:0]  r_row_index, n_row_index;
    logic           r_col_phase, n_col_phase;
    logic           r_row_phase, n_row_phase;

    // Pixel holding registers
    logic signed [PIXEL_BITS-1:0] r_top_left;
    logic signed [PIXEL_BITS-1:0] r_bottom_left;

    // Output register
    logic                         r_out_valid;
    logic signed [PIXEL_BITS-1:0] r_pooled;
    logic [mp2_pkg::MASK_BITS-1:0] r_mask;
    logic                         r_done;

    logic in_acc;
    logic [SW-1:0] eff_w_m1;
    logic [SW-1:0] eff_h_m1;
    logic [SW-1:0] w_ext;
    logic last_col;
    logic last_row;
    logic ram_we;
    logic ram_re;
    logic [2*PIXEL_BITS-1:0] ram_rdata;
    logic signed [PIXEL_BITS-1:0] tl, tr, m1, m2, m3;
    logic [mp2_pkg::MASK_BITS-1:0] mask;
    logic emit;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= CB'(1);
            r_out_height <= CB'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mp2_pkg::CFG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                mp2_pkg::CFG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes less one: zero acts as one, and the width is capped
    // at the line RAM depth.
    always_comb begin
        w_ext = SW'(r_out_width);
        if (w_ext == '0) begin
            eff_w_m1 = '0;
        end else if (w_ext > SW'(MAX_OUT_WIDTH)) begin
            eff_w_m1 = SW'(MAX_OUT_WIDTH - 1);
        end else begin
            eff_w_m1 = w_ext - SW'(1);
        end
        if (r_out_height == '0) begin
            eff_h_m1 = '0;
        end else begin
            eff_h_m1 = SW'(r_out_height) - SW'(1);
        end
    end

    // A counter at or beyond the last index (after a size change) wraps.
    assign last_col = SW'(r_col_index) >= eff_w_m1;
    assign last_row = SW'(r_row_index) >= eff_h_m1;

    // ---------------------------------------------------------------------
    // Handshake: the input stalls only while a result is held and refused.
    // ---------------------------------------------------------------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------------
    // Position counters
    // ---------------------------------------------------------------------
    always_comb begin
        n_col_index = r_col_index;
        n_row_index = r_row_index;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (in_acc) begin
            n_col_phase = !r_col_phase;
            if (r_col_phase) begin
                if (last_col) begin
                    n_col_index = '0;
                    n_row_phase = !r_row_phase;
                    if (r_row_phase) begin
                        n_row_index = last_row ? '0 : r_row_index + CB'(1);
                    end
                end else begin
                    n_col_index = r_col_index + CIW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_index <= '0;
            r_row_index <= '0;
            r_col_phase <= 1'b0;
            r_row_phase <= 1'b0;
        end else begin
            r_col_index <= n_col_index;
            r_row_index <= n_row_index;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    // ---------------------------------------------------------------------
    // Line RAM for the top pair of each window. The top-left pixel waits in
    // a register so that the whole pair is written on the top-right pixel.
    // The read is issued on the bottom-left pixel; the registered read data
    // holds until the bottom-right pixel comes, however long that takes.
    // Reads and writes never fall on the same edge, as they belong to
    // different row phases, so no forwarding is needed.
    // ---------------------------------------------------------------------
    assign ram_we = in_acc && !r_row_phase && r_col_phase;
    assign ram_re = in_acc && r_row_phase && !r_col_phase;

    mp2_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col_index),
        .i_wdata ({i_pixel_value, r_top_left}),
        .i_re    (ram_re),
        .i_raddr (r_col_index),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom_left <= '0;
        end else if (ram_re) begin
            r_bottom_left <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !r_row_phase && !r_col_phase) begin
            r_top_left <= i_pixel_value;
        end
    end

    // ---------------------------------------------------------------------
    // Window maximum and tie mask
    // ---------------------------------------------------------------------
    assign tl = ram_rdata[PIXEL_BITS-1:0];
    assign tr = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];

    always_comb begin
        m1 = (tr > tl) ? tr : tl;
        m2 = (r_bottom_left > m1) ? r_bottom_left : m1;
        m3 = (i_pixel_value > m2) ? i_pixel_value : m2;
        mask = '0;
        mask[mp2_pkg::MASK_TL] = (tl == m3);
        mask[mp2_pkg::MASK_TR] = (tr == m3);
        mask[mp2_pkg::MASK_BL] = (r_bottom_left == m3);
        mask[mp2_pkg::MASK_BR] = (i_pixel_value == m3);
    end

    assign emit = in_acc && r_row_phase && r_col_phase;

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pooled <= m3;
            r_mask   <= mask;
            r_done   <= last_col && last_row;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_pooled;
    assign o_window_mask  = r_mask;
    assign o_map_done     = r_done;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, emit, r_out_valid)
    `ASSERT_SAME(a_mask_not_empty, i_clk, i_rst_n, r_out_valid, r_mask != '0)
    `ASSERT_NEXT(a_map_wraps, i_clk, i_rst_n, emit && last_col && last_row,
        r_col_index == '0 && r_row_index == '0 && !r_row_phase && !r_col_phase)
    `ASSERT_SAME(a_ram_ports_apart, i_clk, i_rst_n, ram_we, !ram_re)

endmodule

[hdl/mp2_ram.sv]
// ---------------------------------------------------------------------------
// mp2_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mp2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
